// ===== hdl/cqac_pkg.sv =====
// Package for the adaptive-capacity circular queue.
// Holds the action and status codes and the request and response payload types.
// No dependencies.
`default_nettype none

package cqac_pkg;

	localparam int CFG_W   = 11;
	localparam int COUNT_W = 11;
	localparam int VALUE_W = 32;

	localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		ACT_QUERY = 2'd0,
		ACT_ENQ   = 2'd1,
		ACT_DEQ   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_EMPTY   = 2'd1,
		STS_DROPPED = 2'd2
	} status_t;

	typedef struct packed {
		action_t                   action;
		logic signed [VALUE_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] taken_value;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
		logic [COUNT_W-1:0]        item_count;
		logic [COUNT_W-1:0]        logical_capacity;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/cqac_ring.sv =====
// Ring storage of the queue: one write port, one read port, registered read data.
// Depends on cqac_pkg for the item width.
`default_nettype none

module cqac_ring import cqac_pkg::*; #(
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(MAX_DEPTH)-1:0]       wr_addr,
	input  wire logic signed [VALUE_W-1:0]          wr_data,
	input  wire logic                               rd_en,
	input  wire logic [$clog2(MAX_DEPTH)-1:0]       rd_addr,
	output logic signed [VALUE_W-1:0]               rd_data
);

	logic signed [VALUE_W-1:0] mem [MAX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cqac_ctrl.sv =====
// Queue controller: head, count and capacity registers, cached front and back items.
// Drives the ring memory ports; depends on cqac_pkg.
`default_nettype none

module cqac_ctrl import cqac_pkg::*; #(
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [CFG_W-1:0]                   cfg_wdata,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire req_t                               req,
	input  wire logic                               slot_free,
	output logic                                    res_valid,
	output rsp_t                                    res,
	output logic                                    wr_en,
	output logic [$clog2(MAX_DEPTH)-1:0]            wr_addr,
	output logic signed [VALUE_W-1:0]               wr_data,
	output logic                                    rd_en,
	output logic [$clog2(MAX_DEPTH)-1:0]            rd_addr,
	input  wire logic signed [VALUE_W-1:0]          rd_data
);

	localparam int AW   = $clog2(MAX_DEPTH);
	localparam int CW   = $clog2(MAX_DEPTH + 1);
	localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam logic [AW-1:0] LAST_SLOT  = AW'(MAX_DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_DEPTH);
	localparam logic [CW-1:0] CAP_MIN    = CW'(2);
	localparam logic [CW-1:0] CAP_SHRINK = CW'(4);

	typedef enum logic {
		ST_IDLE,
		ST_FETCH
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              head_q, head_d, head_inc, tail;
	logic [CW-1:0]              count_q, count_d;
	logic [CW-1:0]              cap_q, cap_d, cap_grown, cfg_cap;
	logic [CW:0]                tail_sum, cap_dbl;
	logic [CMPW-1:0]            cfg_ext;
	logic signed [VALUE_W-1:0]  front_q, front_d, back_q, back_d, taken_q, taken;
	logic                       accept, go_fetch;
	status_t                    status;

	assign req_ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = req_valid && req_ready;

	// Rear slot: head plus count, folded once into the ring.
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail     = (tail_sum >= (CW+1)'(MAX_DEPTH)) ?
		AW'(tail_sum - (CW+1)'(MAX_DEPTH)) : AW'(tail_sum);
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	assign cap_dbl   = {cap_q, 1'b0};
	assign cap_grown = (cap_dbl > (CW+1)'(MAX_DEPTH)) ? FULL_COUNT : CW'(cap_dbl);

	// Clamp the written start capacity into 2..MAX_DEPTH.
	assign cfg_ext = CMPW'(cfg_wdata);
	assign cfg_cap = (cfg_ext < CMPW'(2)) ? CAP_MIN :
		(cfg_ext > CMPW'(MAX_DEPTH)) ? FULL_COUNT : CW'(cfg_ext);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		cap_d    = cap_q;
		front_d  = front_q;
		back_d   = back_q;
		wr_en    = 1'b0;
		wr_addr  = tail;
		wr_data  = req.item_value;
		rd_en    = 1'b0;
		rd_addr  = head_inc;
		go_fetch = 1'b0;
		status   = STS_OK;
		taken    = NONE_VALUE;
		if (state_q == ST_FETCH) begin
			front_d = rd_data;
		end
		if (accept) begin
			unique case (req.action)
				ACT_ENQ: begin
					if (count_q == FULL_COUNT) begin
						status = STS_DROPPED;
					end else begin
						if (count_q >= cap_q) begin
							cap_d = cap_grown;
						end
						wr_en   = 1'b1;
						count_d = count_q + 1'b1;
						back_d  = req.item_value;
						if (count_q == '0) begin
							front_d = req.item_value;
						end
					end
				end
				ACT_DEQ: begin
					if (count_q == '0) begin
						status = STS_EMPTY;
					end else begin
						taken   = front_q;
						head_d  = head_inc;
						count_d = count_q - 1'b1;
						if (cap_q >= CAP_SHRINK && {count_d, 2'b00} < {2'b00, cap_q}) begin
							cap_d = cap_q >> 1;
						end
						// Fetch the new front from the ring when items remain.
						if (count_d != '0) begin
							rd_en    = 1'b1;
							go_fetch = 1'b1;
						end
					end
				end
				ACT_CLEAR: begin
					head_d  = '0;
					count_d = '0;
					cap_d   = CAP_MIN;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_valid = (accept && !go_fetch) || (state_q == ST_FETCH);
		if (state_q == ST_FETCH) begin
			res.status           = STS_OK;
			res.taken_value      = taken_q;
			res.front_value      = rd_data;
			res.back_value       = back_q;
			res.item_count       = COUNT_W'(count_q);
			res.logical_capacity = COUNT_W'(cap_q);
		end else begin
			res.status           = status;
			res.taken_value      = taken;
			res.front_value      = (count_d == '0) ? NONE_VALUE : front_d;
			res.back_value       = (count_d == '0) ? NONE_VALUE : back_d;
			res.item_count       = COUNT_W'(count_d);
			res.logical_capacity = COUNT_W'(cap_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_MIN;
		end else begin
			unique case (state_q)
				ST_IDLE:  state_q <= go_fetch ? ST_FETCH : ST_IDLE;
				ST_FETCH: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			head_q  <= head_d;
			count_q <= count_d;
			if (cfg_we && count_q == '0) begin
				cap_q <= cfg_cap;
			end else begin
				cap_q <= cap_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		front_q <= front_d;
		back_q  <= back_d;
		if (go_fetch) begin
			taken_q <= taken;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cqac_obuf.sv =====
// Two-entry response buffer: output register plus skid register.
// Depends on cqac_pkg for the response type.
`default_nettype none

module cqac_obuf import cqac_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire rsp_t  push_data,
	output logic       slot_free,
	output logic       rsp_valid,
	input  wire logic  rsp_ready,
	output rsp_t       rsp
);

	logic rsp_valid_q, skid_valid_q, pop;
	rsp_t rsp_q, skid_q;

	assign pop       = rsp_valid_q && rsp_ready;
	assign slot_free = !skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			rsp_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (rsp_valid_q) begin
			skid_valid_q <= skid_valid_q || push;
		end else begin
			rsp_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				rsp_q <= push_data;
			end
		end else if (rsp_valid_q) begin
			if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			rsp_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/circular_queue_adaptive_capacity_top.sv =====
// Top level of the adaptive-capacity circular queue.
// Instantiates cqac_ctrl, cqac_ring and cqac_obuf; depends on cqac_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per transfer:
//   query, enqueue, dequeue or clear, with the value to append on enqueue.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per
//   operation, in order: status, dequeued value, front, back, count and
//   logical capacity as they stand after the operation.
//   cfg_we/cfg_wdata write the start capacity (clamped to 2..MAX_DEPTH); the
//   current capacity follows it only while the queue is empty. Write it only
//   while no operation is in flight.
// Result path:
//   Query, enqueue, clear and a dequeue that empties the queue or finds it
//   empty: result formed in the transfer cycle and registered in the rsp buffer,
//   one per cycle while req_ready is high. A dequeue that leaves items behind
//   first reads the new front from the ring; req_ready is low while it fetches.
// Reset: queue empty, head at slot zero, capacity 2; the ring is not cleared.
// Stall: results wait in a two-entry buffer; req_ready drops while two are
//   held and returns as rsp drains.
`default_nettype none

module circular_queue_adaptive_capacity_top import cqac_pkg::*; #(
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp
);

	localparam int AW = $clog2(MAX_DEPTH);

	// Ring memory port signals.
	logic                       wr_en, rd_en;
	logic [AW-1:0]              wr_addr, rd_addr;
	logic signed [VALUE_W-1:0]  wr_data, rd_data;

	// Controller to response buffer.
	logic slot_free, res_valid;
	rsp_t res;

	cqac_ctrl #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// Ring of MAX_DEPTH items; holds the queue body between head and rear.
	cqac_ring #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold finished results while the receiver stalls.
	cqac_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.slot_free (slot_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== hdl/cqac_checker.sv =====
// Port-level checker for the adaptive-capacity circular queue, bound to the top.
// Depends on cqac_pkg and circular_queue_adaptive_capacity_top.
`default_nettype none

module cqac_checker import cqac_pkg::*; #(
	parameter int MAX_DEPTH = 1024
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_we,
	input wire logic [CFG_W-1:0]  cfg_wdata,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire req_t              req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire rsp_t              rsp
);

	// Count and capacity fit the result fields without wrapping.
	localparam bit NARROW = (MAX_DEPTH < 2048);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_EMPTY |->
			rsp.item_count == '0 && rsp.taken_value == NONE_VALUE)
		else $error("empty dequeue reported items or a value");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW && rsp.item_count == '0 |->
			rsp.front_value == NONE_VALUE && rsp.back_value == NONE_VALUE)
		else $error("empty queue reported a front or back item");

	a_cap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW |->
			rsp.item_count <= rsp.logical_capacity && rsp.logical_capacity >= COUNT_W'(2))
		else $error("count exceeds capacity or capacity below two");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW && rsp.status == STS_DROPPED |->
			rsp.item_count == COUNT_W'(MAX_DEPTH))
		else $error("enqueue dropped while queue not at maximum");

endmodule

bind circular_queue_adaptive_capacity_top cqac_checker #(
	.MAX_DEPTH (MAX_DEPTH)
) u_cqac_checker (.*);

`default_nettype wire

// ===== dv/circular_queue_adaptive_capacity_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_queue_adaptive_capacity_top.
// Drives queue operations on req, checks every rsp against an in-bench queue predictor.
// Depends on cqac_pkg and the queue RTL under hdl/.

module circular_queue_adaptive_capacity_top_tb;
	import cqac_pkg::*;

	localparam int MAX_DEPTH    = 1024;
	localparam int DRAIN_CYCLES = 8;         // settle margin after the last result, longer than a dequeue takes
	localparam int HOLD_AT      = 700;       // rsp transfers before the long receiver hold
	localparam int HOLD_LEN     = 80;        // cycles of the long receiver hold
	localparam longint LIMIT_NS = 3_000_000; // run guard, far above the slowest legal run

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;

	circular_queue_adaptive_capacity_top #(
		.MAX_DEPTH(MAX_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Operations waiting for the driver, and results the queue still owes us.
	req_t ops_to_send [$];
	rsp_t results_due [$];

	// Predicted queue contents and capacity bookkeeping.
	logic signed [VALUE_W-1:0] model_ring [MAX_DEPTH];
	int model_head     = 0;
	int model_count    = 0;
	int model_cap      = 2;
	int model_start    = 2;

	int  mismatches    = 0;
	bit  quiet         = 1'b0;  // set for the closing stretch: no idling on either side
	int  gap_left      = 0;
	int  stall_left    = 0;
	int  hold_left     = 0;
	bit  hold_done     = 1'b0;
	int  drained       = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one operation to the predicted queue and return the result it should produce.
	function automatic rsp_t apply_operation(input req_t op);
		rsp_t r;
		r.status      = STS_OK;
		r.taken_value = NONE_VALUE;
		case (op.action)
			ACT_QUERY: begin
			end
			ACT_ENQ: begin
				if (model_count >= MAX_DEPTH) begin
					r.status = STS_DROPPED;
				end else begin
					// grow before appending when full, saturating at the ring size
					if (model_count >= model_cap)
						model_cap = (model_cap * 2 > MAX_DEPTH) ? MAX_DEPTH : model_cap * 2;
					model_ring[(model_head + model_count) % MAX_DEPTH] = op.item_value;
					model_count++;
				end
			end
			ACT_DEQ: begin
				if (model_count == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.taken_value = model_ring[model_head];
					model_head = (model_head + 1) % MAX_DEPTH;
					model_count--;
					// shrink when the queue uses under a quarter of its capacity
					if (model_cap >= 4 && model_count * 4 < model_cap)
						model_cap = model_cap / 2;
				end
			end
			ACT_CLEAR: begin
				model_head  = 0;
				model_count = 0;
				model_cap   = 2;
			end
		endcase
		if (model_count == 0) begin
			r.front_value = NONE_VALUE;
			r.back_value  = NONE_VALUE;
		end else begin
			r.front_value = model_ring[model_head];
			r.back_value  = model_ring[(model_head + model_count - 1) % MAX_DEPTH];
		end
		r.item_count       = COUNT_W'(model_count);
		r.logical_capacity = COUNT_W'(model_cap);
		return r;
	endfunction

	function automatic action_t pick_action(input int enq_w, input int deq_w, input int qry_w);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < enq_w)
			return ACT_ENQ;
		if (roll < enq_w + deq_w)
			return ACT_DEQ;
		if (roll < enq_w + deq_w + qry_w)
			return ACT_QUERY;
		return ACT_CLEAR;
	endfunction

	// Mostly full-range random values, with the corner values mixed in.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input action_t act, input logic signed [VALUE_W-1:0] val);
		req_t op;
		op.action     = act;
		op.item_value = val;
		ops_to_send.push_back(op);
	endtask

	task automatic queue_random_ops(input int n, input int enq_w, input int deq_w,
			input int qry_w);
		repeat (n)
			queue_op(pick_action(enq_w, deq_w, qry_w), pick_value());
	endtask

	// Block until every queued operation is sent and answered, then let the
	// pipeline settle so nothing is in flight.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (ops_to_send.size() != 0 || req_valid || results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the start capacity; only called while the queue is idle.
	task automatic write_start_capacity(input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_start = (val < 2) ? 2 : (val > MAX_DEPTH) ? MAX_DEPTH : int'(val);
		// a fresh queue picks up the new capacity, a loaded one keeps its own
		if (model_count == 0)
			model_cap = model_start;
		@(negedge clk);
	endtask

	// Driver: predict at each accepted transfer, then advance to the next
	// pending operation or hold the current one while req_ready is low.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid && req_ready)
				results_due.push_back(apply_operation(req));
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (ops_to_send.size() != 0) begin
					req       <= ops_to_send.pop_front();
					req_valid <= 1'b1;
					// start an idle burst after this transfer now and then
					if (!quiet && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 7);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold so the result buffer
	// fills and req_ready drops while the driver keeps offering operations.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready)
				drained++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!hold_done && drained >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Monitor: compare each rsp transfer against the oldest predicted result.
	always @(posedge clk) begin : rsp_monitor
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t ns: result with no operation outstanding", $time);
			end else begin
				want = results_due.pop_front();
				check_field("status", VALUE_W'(want.status), VALUE_W'(rsp.status));
				check_field("taken_value", want.taken_value, rsp.taken_value);
				check_field("front_value", want.front_value, rsp.front_value);
				check_field("back_value", want.back_value, rsp.back_value);
				check_field("item_count", VALUE_W'(want.item_count), VALUE_W'(rsp.item_count));
				check_field("logical_capacity", VALUE_W'(want.logical_capacity),
					VALUE_W'(rsp.logical_capacity));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset capacity, empty-queue corners, growth, shrink, clear.
		queue_op(ACT_QUERY, 32'sd0);              // front and back of an empty queue
		queue_op(ACT_DEQ,   32'sd5);              // dequeue with nothing held
		queue_op(ACT_ENQ,   32'sh7FFF_FFFF);
		queue_op(ACT_ENQ,   32'sh8000_0000);
		queue_op(ACT_ENQ,   -32'sd1);             // full at capacity 2: grows to 4
		queue_op(ACT_ENQ,   32'sd0);
		queue_op(ACT_ENQ,   32'sh5555_5555);      // grows to 8
		queue_op(ACT_QUERY, 32'shAAAA_AAAA);
		repeat (5)
			queue_op(ACT_DEQ, 32'sd0);            // shrinks on the way down to empty
		queue_op(ACT_DEQ,   32'sd0);
		queue_op(ACT_ENQ,   32'shAAAA_AAAA);
		queue_op(ACT_ENQ,   32'sd1);
		queue_op(ACT_CLEAR, 32'sh1234_5678);
		queue_op(ACT_QUERY, 32'sd0);
		queue_op(ACT_ENQ,   32'sd42);
		queue_op(ACT_DEQ,   32'sd0);
		queue_op(ACT_ENQ,   32'sd7);
		queue_op(ACT_ENQ,   32'sd8);
		queue_op(ACT_CLEAR, 32'sd0);
		wait_drained();

		// Mid-range start capacity, balanced mix.
		write_start_capacity(CFG_W'($urandom_range(3, MAX_DEPTH - 1)));
		queue_random_ops(60, 50, 35, 10);
		queue_op(ACT_CLEAR, pick_value());
		wait_drained();

		// Below-range write clamps up to 2; grow-heavy mix.
		write_start_capacity('0);
		queue_random_ops(100, 60, 30, 5);
		queue_op(ACT_CLEAR, pick_value());
		wait_drained();

		// All-ones write clamps to the ring size; shrink from the top.
		write_start_capacity('1);
		repeat (30)
			queue_op(ACT_ENQ, pick_value());
		queue_random_ops(70, 30, 60, 5);
		queue_op(ACT_CLEAR, pick_value());
		wait_drained();

		// Walk the head forward, then fill the ring past its end so it wraps,
		// grows all the way and starts dropping. The long receiver hold lands here.
		write_start_capacity(CFG_W'(1));
		repeat (100) begin
			queue_op(ACT_ENQ, pick_value());
			queue_op(ACT_DEQ, pick_value());
		end
		repeat (MAX_DEPTH)
			queue_op(ACT_ENQ, pick_value());
		queue_op(ACT_ENQ,   pick_value());        // dropped
		queue_op(ACT_ENQ,   pick_value());        // dropped
		queue_op(ACT_DEQ,   pick_value());
		queue_op(ACT_ENQ,   pick_value());        // fits again
		queue_op(ACT_ENQ,   pick_value());        // dropped
		queue_op(ACT_QUERY, pick_value());
		wait_drained();

		// Write while the queue is loaded: capacity must stay put. No idling
		// from here to the end.
		write_start_capacity(CFG_W'(MAX_DEPTH));
		quiet = 1'b1;
		queue_random_ops(130, 30, 60, 5);
		wait_drained();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Timeout: queue stopped making progress");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
